// File: rtl/sorted_priority_queue_unit_macros.svh
// Assertion macros used by the priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spq_pkg.sv
// Types, constants and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;
   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd2;

   localparam logic [STAT_W-1:0] ST_ENTRY    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      ext;
      entry_type new_entry;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// File: rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: handshake, occupancy and the cell chain.
// A min-priority queue of DEPTH entries held in a chain of cells kept in ascending
// priority order; every cell compares the incoming priority with its own and the
// whole chain shifts as a whole, so it accepts one item per clock cycle while results
// are taken; the result appears on rsp_ in the cycle after acceptance. Each item
// gives exactly one result. An insert goes ahead of the first entry of equal or
// greater priority; an insert into a full queue is dropped with status full, and
// extract or peek on an empty queue returns status empty. Operation code 3 acts as
// a peek. While a result waits in the result register, req_tready stays low, and
// the next item is taken in the cycle that the waiting result is accepted.
`default_nettype none
`include "sorted_priority_queue_unit_macros.svh"
module sorted_priority_queue_unit
   import spq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [2*DATA_W-1:0] req_tdata,   // value [31:0], prio [63:32]
   input  wire logic [FUNC_W-1:0]   req_tuser,   // func [1:0]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [2*DATA_W-1:0]      rsp_tdata,   // out_value [31:0], out_prio [63:32]
   output logic [STAT_W-1:0]        rsp_tuser    // status [1:0]
);
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type        rsp_entry_ff, rsp_entry_in;

   logic          accept;
   logic          is_insert, is_extract, full, empty;
   cell_ctrl_type ctrl;
   entry_type     entries [DEPTH];
   logic          takes   [DEPTH];
   entry_type     zero_entry;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_insert  = (req_tuser == FUNC_INSERT);
   assign is_extract = (req_tuser == FUNC_EXTRACT);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign zero_entry = '0;

   assign ctrl.ins             = accept && is_insert && !full;
   assign ctrl.ext             = accept && is_extract && !empty;
   assign ctrl.new_entry.value = req_tdata[DATA_W-1:0];
   assign ctrl.new_entry.prio  = req_tdata[2*DATA_W-1:DATA_W];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic      occupied;
      logic      left_take;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (IDX < count_ff);
      if (i == 0) begin : g_head
         assign left_take  = 1'b0;
         assign left_entry = zero_entry;
      end else begin : g_body
         assign left_take  = takes[i-1];
         assign left_entry = entries[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = zero_entry;
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .left_take   (left_take),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .take        (takes[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = zero_entry;
         priority if (is_insert) begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_status_in = ST_INSERTED;
               count_in      = count_ff + 1'b1;
            end
         end else if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in = ST_ENTRY;
            rsp_entry_in  = entries[0];
            if (is_extract) begin
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_entry_ff.prio, rsp_entry_ff.value};
   assign rsp_tuser  = rsp_status_ff;

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "occupancy above depth")
   `SPQ_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_tvalid, "accepted item gave no result")
   `SPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_ff == $past(count_ff) + 1'b1,
      "insert did not grow the queue")
   `SPQ_ASSERT_NEXT(a_extract_shrinks, ctrl.ext, count_ff == $past(count_ff) - 1'b1,
      "extract did not shrink the queue")
   `SPQ_ASSERT_NOW(a_one_op, 1'b1, !(ctrl.ins && ctrl.ext), "insert and extract together")
endmodule
`default_nettype wire

// File: rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire logic          left_take,
   input  wire entry_type     left_entry,
   input  wire entry_type     right_entry,
   output logic               take,
   output entry_type          entry
);
   entry_type entry_ff;
   entry_type entry_in;

   // An empty slot acts as an infinite priority, so the new entry lands there.
   assign take = !occupied || (ctrl.new_entry.prio <= entry_ff.prio);

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.ins) begin
         if (left_take) begin
            entry_in = left_entry;
         end else if (take) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.ext) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

// File: tb/sv/tb_sorted_priority_queue_unit.sv
// Self-checking testbench for the sorted priority queue: random stream traffic checked against a local queue predictor.
module tb_sorted_priority_queue_unit;
   import spq_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_PEEK_ALT = 2'd3;   // unused code, behaves as a peek
   localparam int RANDOM_ITEMS = 1150;
   localparam int PRESSURE_AT  = 400;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic signed [DATA_W-1:0] DIRECTED_PRIOS [16] = '{
      32'sh7fffffff, 32'sh80000000, 0, -1, 5, 5, 32'sh80000000, 3,
      32'sh7fffffff, -7, 100, 0, 1, -1, 42, 9};
   localparam logic [DATA_W-1:0] DIRECTED_VALUES [16] = '{
      32'hffffffff, 32'h00000000, 32'h80000000, 32'h7fffffff,
      32'h5555aaaa, 32'haaaa5555, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10};

   class priority_queue_scoreboard;
      typedef struct {
         logic [STAT_W-1:0] status;
         logic [DATA_W-1:0] value;
         logic [DATA_W-1:0] prio;
      } queue_result_type;

      entry_type        sorted_entries [DEPTH];
      int               entry_count;
      queue_result_type pending_results [$];
      int               mismatches;
      int               status_seen [4];

      function new();
         entry_count = 0;
         mismatches  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Applies one operation to the sorted list and returns what the block must answer.
      function queue_result_type predict_queue_op(logic [FUNC_W-1:0] func,
                                                  logic signed [DATA_W-1:0] value,
                                                  logic signed [DATA_W-1:0] prio);
         queue_result_type r;
         int pos;
         r.status = ST_INSERTED;
         r.value  = '0;
         r.prio   = '0;
         if (func == FUNC_INSERT) begin
            if (entry_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // The new entry goes ahead of the first entry of equal or greater priority.
               pos = 0;
               while (pos < entry_count && prio > sorted_entries[pos].prio) pos++;
               for (int i = entry_count; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
               sorted_entries[pos].value = value;
               sorted_entries[pos].prio  = prio;
               entry_count++;
            end
         end else if (entry_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.status = ST_ENTRY;
            r.value  = sorted_entries[0].value;
            r.prio   = sorted_entries[0].prio;
            if (func == FUNC_EXTRACT) begin
               for (int i = 1; i < entry_count; i++) sorted_entries[i-1] = sorted_entries[i];
               entry_count--;
            end
         end
         return r;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value,
                                 logic [DATA_W-1:0] prio);
         pending_results.push_back(predict_queue_op(func, value, prio));
      endfunction

      task check_response(logic [STAT_W-1:0] status, logic [DATA_W-1:0] value,
                          logic [DATA_W-1:0] prio);
         queue_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no item pending (status %0d)", status));
         end else begin
            want = pending_results.pop_front();
            status_seen[want.status]++;
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            if (value !== want.value)
               report_mismatch($sformatf("out_value %h, expected %h", value, want.value));
            if (prio !== want.prio)
               report_mismatch($sformatf("out_prio %h, expected %h", prio, want.prio));
         end
      endtask

      task flush_leftovers();
         while (pending_results.size() != 0) begin
            report_mismatch($sformatf("result never arrived (status %0d)",
                                      pending_results[0].status));
            void'(pending_results.pop_front());
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [2*DATA_W-1:0] req_tdata = '0;   // value [31:0], prio [63:32]
   logic [FUNC_W-1:0]   req_tuser = '0;   // func [1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [2*DATA_W-1:0] rsp_tdata;       // out_value [31:0], out_prio [63:32]
   logic [STAT_W-1:0]   rsp_tuser;       // status [1:0]

   priority_queue_scoreboard sb = new();
   int cycle_count   = 0;
   int items_sent    = 0;
   int hold_request  = 0;
   bit no_idle       = 1'b0;

   sorted_priority_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Both handshakes are observed in one place so an item is always noted before its result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[DATA_W-1:0], req_tdata[2*DATA_W-1:DATA_W]);
         if (rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[DATA_W-1:0], rsp_tdata[2*DATA_W-1:DATA_W]);
      end
   end

   // Result side: a random stall after each taken item, or a long hold when one is requested.
   initial begin
      int stall_left;
      bit taken;
      stall_left = 0;
      forever begin
         @(posedge clock);
         taken = rsp_tvalid && rsp_tready;
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (taken) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               sb.pending_count());
      $display("CHECK FAILED");
      $finish;
   end

   // Called and returns at a falling edge; valid stays high into the next item when it has no gap.
   task automatic send_item(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value,
                            logic [DATA_W-1:0] prio);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, value};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] draw_prio();
      int k;
      case ($urandom_range(0, 3))
         0: begin
            // Narrow range so equal priorities are common.
            k = $urandom_range(0, 8);
            return k - 4;
         end
         1: return $urandom;
         2: begin
            case ($urandom_range(0, 5))
               0: return 32'sh80000000;
               1: return 32'sh80000001;
               2: return 32'sh7fffffff;
               3: return 32'sh7ffffffe;
               4: return 0;
               default: return -1;
            endcase
         end
         default: begin
            k = $urandom_range(0, 65535);
            return k - 32768;
         end
      endcase
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(int ins_pct, int ext_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) return FUNC_INSERT;
      if (r < ins_pct + ext_pct) return FUNC_EXTRACT;
      return ($urandom_range(0, 3) == 0) ? FUNC_PEEK_ALT : FUNC_PEEK;
   endfunction

   task automatic send_random_run(int ins_pct, int ext_pct, int run_len);
      for (int n = 0; n < run_len; n++)
         send_item(pick_func(ins_pct, ext_pct), $urandom, draw_prio());
   endtask

   initial begin
      int random_base;
      bit pressure_done;
      pressure_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Operations on an empty queue, a fill to capacity with extreme and equal priorities, then full-queue operations.
      send_item(FUNC_PEEK, 32'hffffffff, 32'hffffffff);
      send_item(FUNC_EXTRACT, 32'hffffffff, 32'hffffffff);
      send_item(FUNC_PEEK_ALT, 32'h0, 32'h0);
      for (int i = 0; i < 16; i++)
         send_item(FUNC_INSERT, DIRECTED_VALUES[i], DIRECTED_PRIOS[i]);
      send_item(FUNC_INSERT, 32'hdeadbeef, 32'sh80000000);
      send_item(FUNC_PEEK, 32'h0, 32'h0);
      send_item(FUNC_PEEK_ALT, 32'h0, 32'h0);
      send_item(FUNC_EXTRACT, 32'h0, 32'h0);

      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 2))
            0: send_random_run(85, 10, $urandom_range(8, 40));
            1: send_random_run(15, 70, $urandom_range(8, 40));
            default: send_random_run(45, 35, $urandom_range(8, 40));
         endcase
         if (!pressure_done && items_sent - random_base > PRESSURE_AT) begin
            // Hold the result side for a long stretch while items keep coming back to back.
            pressure_done = 1'b1;
            hold_request  = HOLD_CYCLES;
            no_idle       = 1'b1;
            send_random_run(50, 30, 30);
            no_idle = 1'b0;
            wait_for_results();
         end else if ($urandom_range(0, 9) == 0) begin
            wait_for_results();
         end
      end

      no_idle = 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flush_leftovers();
      $display("Ran %0d items: %0d inserts stored, %0d dropped on a full queue,",
               items_sent, sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL]);
      $display("%0d minimum entries returned, %0d empty answers, %0d mismatches.",
               sb.status_seen[ST_ENTRY], sb.status_seen[ST_EMPTY], sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
